>>> sv/tce_pkg.sv
package tce_pkg;

    // fixed geometry of the execute unit
    localparam int WORD_BITS    = 32;
    localparam int PC_BITS      = 16;
    localparam int NUM_REGS     = 16;
    localparam int MEM_WORDS    = 256;
    localparam int REG_IDX_BITS = 4;
    localparam int ADDR_BITS    = 8;
    localparam int KIND_BITS    = 4;
    localparam int OPND_BITS    = 8;
    localparam int CYC_BITS     = 5;

    // stream widths
    localparam int IN_TDATA_BITS  = 16;
    localparam int OUT_TDATA_BITS = 104;

    typedef logic [WORD_BITS-1:0]    word_t;
    typedef logic [REG_IDX_BITS-1:0] reg_idx_t;
    typedef logic [ADDR_BITS-1:0]    addr_t;
    typedef logic [PC_BITS-1:0]      pc_t;
    typedef logic [CYC_BITS-1:0]     cyc_t;

    // instruction kinds
    typedef enum logic [KIND_BITS-1:0] {
        K_LD_DIR = 4'd0,
        K_ST_DIR = 4'd1,
        K_ST_IND = 4'd2,
        K_LD_IMM = 4'd3,
        K_ADD    = 4'd4,
        K_SUB    = 4'd5,
        K_JZ     = 4'd6,
        K_MUL    = 4'd7,
        K_MOV    = 4'd8,
        K_LD_IND = 4'd9
    } kind_t;

    // register file write port
    typedef struct packed {
        logic     we;
        reg_idx_t idx;
        word_t    data;
    } rf_wr_t;

    // result fields, first field in the highest bits
    typedef struct packed {
        word_t    mem_value;
        addr_t    dm_addr;
        logic     mem_we;
        word_t    reg_value;
        reg_idx_t rf_index;
        logic     reg_we;
        cyc_t     cycles;
        logic [15:0] next_pc;
    } result_t;

    // one queued result beat
    typedef struct packed {
        logic    illegal;
        result_t data;
    } out_item_t;

    // cycle cost per kind, zero for unknown kinds
    function automatic cyc_t cycle_cost(input logic [KIND_BITS-1:0] kind);
        cyc_t cost;
        unique case (kind)
            K_LD_DIR: cost = 5'd8;
            K_ST_DIR: cost = 5'd8;
            K_ST_IND: cost = 5'd12;
            K_LD_IMM: cost = 5'd6;
            K_ADD:    cost = 5'd4;
            K_SUB:    cost = 5'd4;
            K_JZ:     cost = 5'd12;
            K_MUL:    cost = 5'd30;
            K_MOV:    cost = 5'd2;
            K_LD_IND: cost = 5'd12;
            default:  cost = 5'd0;
        endcase
        return cost;
    endfunction

endpackage

>>> sv/tiny_cpu_execute_unit.sv
// path: an accepted instruction beat goes through stage 1, stage 2 and the result queue to its result beat
// issue: a new instruction is taken only while stage 1 is empty, as set by the registered
// register file read followed by the data memory read and write-back
// results wait in a 2-entry queue; input stalls once queue and flight fill it
// reset: pc, valid flags and queue cleared at once; unwritten registers
// and memory words read as zero, no clearing pass
module tiny_cpu_execute_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tce_pkg::IN_TDATA_BITS-1:0]  s_tdata,   // dest_reg, operand
    input  logic [tce_pkg::KIND_BITS-1:0]      s_tuser,   // kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // next_pc, cycles, reg_we, rf_index, reg_value, mem_we, dm_addr, mem_value
    output logic [tce_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    output logic                               m_tuser    // illegal
);
    import tce_pkg::*;

    logic                 s_fire;
    logic                 v1_reg, v2_reg;
    logic [1:0]           fifo_count;
    logic [1:0]           fifo_load;

    // stage 1: operands arrive from the register file
    logic [KIND_BITS-1:0] s1_kind_reg;
    reg_idx_t             s1_rn_reg;
    logic [OPND_BITS-1:0] s1_opnd_reg;
    word_t                op_a, op_b;
    reg_idx_t             rd_addr_b;
    word_t                prod_low;
    word_t                s1_alu;
    addr_t                s1_addr;
    word_t                s1_mval;
    logic                 s1_reg_we, s1_mem_we, s1_load, s1_illegal;

    // stage 2: memory data arrives, write-back
    logic                 s2_illegal_reg, s2_reg_we_reg, s2_mem_we_reg;
    logic                 s2_load_reg, s2_taken_reg;
    reg_idx_t             s2_rn_reg;
    word_t                s2_alu_reg, s2_mval_reg;
    addr_t                s2_addr_reg;
    logic [OPND_BITS-1:0] s2_opnd_reg;
    cyc_t                 s2_cycles_reg;

    // data memory
    word_t                dm_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] dm_vld_reg;
    word_t                dm_rd_reg;
    logic                 dm_rd_vld_reg;
    logic                 dm_we;

    pc_t                  pc_reg, pc_inc, pc_jump, pc_next;
    word_t                s2_rval;
    rf_wr_t               rf_wr;
    out_item_t            res;
    out_item_t            fifo_out;

    // accept when stage 1 is free and the queue has room for everything in flight
    assign fifo_load = fifo_count + {1'b0, v2_reg};
    assign s_tready  = aresetn && !v1_reg && (fifo_load < 2'd2);
    assign s_fire    = s_tvalid && s_tready;

    // second read port takes the low or high operand nibble
    assign rd_addr_b = (s_tuser == K_ST_IND || s_tuser == K_LD_IND) ?
                       s_tdata[7:4] : s_tdata[11:8];

    tce_rf u_rf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_fire),
        .rd_addr_a (s_tdata[3:0]),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (op_a),
        .rd_data_b (op_b),
        .wr        (rf_wr)
    );

    // pipeline occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= s_fire;
            v2_reg <= v1_reg;
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_kind_reg <= s_tuser;
            s1_rn_reg   <= s_tdata[3:0];
            s1_opnd_reg <= s_tdata[11:4];
        end
    end

    assign prod_low = op_a * op_b;

    // stage 1 decode and arithmetic
    always_comb begin
        s1_alu     = '0;
        s1_addr    = '0;
        s1_mval    = '0;
        s1_reg_we  = 1'b0;
        s1_mem_we  = 1'b0;
        s1_load    = 1'b0;
        s1_illegal = 1'b0;
        unique case (s1_kind_reg)
            K_LD_DIR: begin
                s1_reg_we = 1'b1;
                s1_load   = 1'b1;
                s1_addr   = s1_opnd_reg;
            end
            K_ST_DIR: begin
                s1_mem_we = 1'b1;
                s1_addr   = s1_opnd_reg;
                s1_mval   = op_a;
            end
            K_ST_IND: begin
                s1_mem_we = 1'b1;
                s1_addr   = op_a[ADDR_BITS-1:0];
                s1_mval   = op_b;
            end
            K_LD_IMM: begin
                s1_reg_we = 1'b1;
                s1_alu    = {{(WORD_BITS-OPND_BITS){1'b0}}, s1_opnd_reg};
            end
            K_ADD: begin
                s1_reg_we = 1'b1;
                s1_alu    = op_a + op_b;
            end
            K_SUB: begin
                s1_reg_we = 1'b1;
                s1_alu    = op_a - op_b;
            end
            K_JZ: begin
                s1_alu = '0;
            end
            K_MUL: begin
                s1_reg_we = 1'b1;
                s1_alu    = prod_low;
            end
            K_MOV: begin
                s1_reg_we = 1'b1;
                s1_alu    = op_b;
            end
            K_LD_IND: begin
                s1_reg_we = 1'b1;
                s1_load   = 1'b1;
                s1_addr   = op_b[ADDR_BITS-1:0];
            end
            default: begin
                s1_illegal = 1'b1;
            end
        endcase
    end

    // stage 2 payload
    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            s2_illegal_reg <= s1_illegal;
            s2_reg_we_reg  <= s1_reg_we;
            s2_mem_we_reg  <= s1_mem_we;
            s2_load_reg    <= s1_load;
            s2_taken_reg   <= (s1_kind_reg == K_JZ) && (op_a == '0);
            s2_rn_reg      <= s1_rn_reg;
            s2_alu_reg     <= s1_alu;
            s2_mval_reg    <= s1_mval;
            s2_addr_reg    <= s1_addr;
            s2_opnd_reg    <= s1_opnd_reg;
            s2_cycles_reg  <= cycle_cost(s1_kind_reg);
        end
    end

    // data memory: read in stage 1, write at the end of stage 2
    assign dm_we = v2_reg && s2_mem_we_reg;

    always_ff @(posedge aclk) begin
        if (dm_we) begin
            dm_mem[s2_addr_reg] <= s2_mval_reg;
        end
        if (v1_reg) begin
            dm_rd_reg     <= dm_mem[s1_addr];
            dm_rd_vld_reg <= dm_vld_reg[s1_addr];
        end
    end

    // written flags of the data memory
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dm_vld_reg <= '0;
        end else if (dm_we) begin
            dm_vld_reg[s2_addr_reg] <= 1'b1;
        end
    end

    // stage 2 write-back value and next pc
    assign s2_rval = s2_load_reg ? (dm_rd_vld_reg ? dm_rd_reg : '0) : s2_alu_reg;
    assign pc_inc  = pc_reg + pc_t'(1);
    assign pc_jump = pc_inc + {{(PC_BITS-OPND_BITS){1'b0}}, s2_opnd_reg};
    assign pc_next = s2_illegal_reg ? pc_reg : (s2_taken_reg ? pc_jump : pc_inc);

    assign rf_wr.we   = v2_reg && s2_reg_we_reg;
    assign rf_wr.idx  = s2_rn_reg;
    assign rf_wr.data = s2_rval;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else if (v2_reg) begin
            pc_reg <= pc_next;
        end
    end

    // result beat, unused fields forced to zero
    always_comb begin
        res                = '0;
        res.illegal        = s2_illegal_reg;
        res.data.next_pc   = pc_next;
        res.data.cycles    = s2_cycles_reg;
        res.data.reg_we    = s2_reg_we_reg;
        res.data.rf_index  = s2_reg_we_reg ? s2_rn_reg : '0;
        res.data.reg_value = s2_reg_we_reg ? s2_rval : '0;
        res.data.mem_we    = s2_mem_we_reg;
        res.data.dm_addr   = s2_mem_we_reg ? s2_addr_reg : '0;
        res.data.mem_value = s2_mem_we_reg ? s2_mval_reg : '0;
    end

    tce_ofifo u_ofifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (v2_reg),
        .push_data (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (fifo_out),
        .count     (fifo_count)
    );

    assign m_tdata = {{(OUT_TDATA_BITS-$bits(result_t)){1'b0}}, fifo_out.data};
    assign m_tuser = fifo_out.illegal;

    // an instruction in stage 1 always moves on to stage 2
    a_stage_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |=> v2_reg)
        else $error("instruction lost between stages");

    // an unknown kind never touches state
    a_illegal_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && s2_illegal_reg) |-> !(rf_wr.we || dm_we))
        else $error("illegal instruction wrote state");

    // every legal instruction moves the pc
    a_pc_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !s2_illegal_reg) |=> pc_reg != $past(pc_reg))
        else $error("pc did not advance");

endmodule

>>> sv/tce_rf.sv
module tce_rf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  tce_pkg::reg_idx_t     rd_addr_a,
    input  tce_pkg::reg_idx_t     rd_addr_b,
    output tce_pkg::word_t        rd_data_a,
    output tce_pkg::word_t        rd_data_b,
    input  tce_pkg::rf_wr_t       wr
);
    import tce_pkg::*;

    word_t              rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    word_t              data_a_reg, data_b_reg;
    reg_idx_t           addr_a_reg, addr_b_reg;
    logic               vld_a_reg, vld_b_reg;
    logic               fwd_we_reg;
    reg_idx_t           fwd_idx_reg;
    word_t              fwd_data_reg;

    // storage, registered read ports and last-write capture
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            rf_mem[wr.idx] <= wr.data;
        end
        if (rd_en) begin
            data_a_reg <= rf_mem[rd_addr_a];
            data_b_reg <= rf_mem[rd_addr_b];
            addr_a_reg <= rd_addr_a;
            addr_b_reg <= rd_addr_b;
            vld_a_reg  <= vld_reg[rd_addr_a];
            vld_b_reg  <= vld_reg[rd_addr_b];
        end
        fwd_idx_reg  <= wr.idx;
        fwd_data_reg <= wr.data;
    end

    // written flags, an unwritten register reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            fwd_we_reg <= 1'b0;
        end else begin
            fwd_we_reg <= wr.we;
            if (wr.we) begin
                vld_reg[wr.idx] <= 1'b1;
            end
        end
    end

    // forward a write that landed on the same edge as the read
    assign rd_data_a = (fwd_we_reg && fwd_idx_reg == addr_a_reg) ? fwd_data_reg :
                       (vld_a_reg ? data_a_reg : '0);
    assign rd_data_b = (fwd_we_reg && fwd_idx_reg == addr_b_reg) ? fwd_data_reg :
                       (vld_b_reg ? data_b_reg : '0);

endmodule

>>> sv/tce_ofifo.sv
module tce_ofifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  tce_pkg::out_item_t    push_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tce_pkg::out_item_t    out_data,
    output logic [1:0]            count
);
    import tce_pkg::*;

    out_item_t  entry_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_mem[rd_ptr_reg];
    assign count     = count_reg;

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // space is reserved before an instruction is taken
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg != 2'd2)
        else $error("result queue overflow");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    import tce_pkg::*;

    // kinds above the last implemented one are flagged illegal
    localparam logic [KIND_BITS-1:0] KIND_BAD_FIRST = 4'd10;
    localparam logic [KIND_BITS-1:0] KIND_BAD_LAST  = 4'd15;
    localparam int                   CYCLE_LIMIT    = 200000;
    localparam int                   DRAIN_CYCLES   = 8;

    // cycle cost of each implemented kind
    localparam cyc_t COST_OF [K_LD_IND+1] = '{8, 8, 12, 6, 4, 4, 12, 30, 2, 12};

    // one expected result beat
    typedef struct packed {
        pc_t      next_pc;
        cyc_t     cycles;
        logic     illegal;
        logic     reg_we;
        reg_idx_t rf_index;
        word_t    reg_value;
        logic     mem_we;
        addr_t    dm_addr;
        word_t    mem_value;
    } exec_result_t;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata  = '0;
    logic [KIND_BITS-1:0]      s_tuser  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tuser;

    // architectural state mirrored by the predictor
    word_t arch_regs [NUM_REGS];
    word_t arch_mem  [MEM_WORDS];
    pc_t   arch_pc;

    exec_result_t expected_results [$];
    bit           in_taken;
    bit           idle_en = 1'b1;
    int           rx_stall_left = 0;
    int           error_count = 0;
    int           cycle_count = 0;

    tiny_cpu_execute_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // execute one instruction on the mirrored state
    function automatic exec_result_t execute_instr(logic [KIND_BITS-1:0] kind,
                                                   reg_idx_t rn, logic [7:0] opnd);
        exec_result_t r;
        pc_t          pc_next;
        reg_idx_t     rm_hi;
        reg_idx_t     rm_lo;
        r       = '0;
        rm_hi   = opnd[7:4];
        rm_lo   = opnd[3:0];
        pc_next = arch_pc + 1'b1;
        if (kind > K_LD_IND) begin
            r.next_pc = arch_pc;
            r.illegal = 1'b1;
            return r;
        end
        r.cycles = COST_OF[kind];
        case (kind)
            K_LD_DIR: begin
                r.reg_we = 1'b1; r.rf_index = rn; r.reg_value = arch_mem[opnd];
            end
            K_ST_DIR: begin
                r.mem_we = 1'b1; r.dm_addr = opnd; r.mem_value = arch_regs[rn];
            end
            K_ST_IND: begin
                r.mem_we    = 1'b1;
                r.dm_addr   = arch_regs[rn][ADDR_BITS-1:0];
                r.mem_value = arch_regs[rm_lo];
            end
            K_LD_IMM: begin
                r.reg_we = 1'b1; r.rf_index = rn; r.reg_value = word_t'(opnd);
            end
            K_ADD: begin
                r.reg_we = 1'b1; r.rf_index = rn;
                r.reg_value = arch_regs[rn] + arch_regs[rm_hi];
            end
            K_SUB: begin
                r.reg_we = 1'b1; r.rf_index = rn;
                r.reg_value = arch_regs[rn] - arch_regs[rm_hi];
            end
            K_JZ: begin
                // taken jump skips the unsigned offset, wrapping
                if (arch_regs[rn] == '0)
                    pc_next = pc_next + pc_t'(opnd);
            end
            K_MUL: begin
                r.reg_we = 1'b1; r.rf_index = rn;
                r.reg_value = arch_regs[rn] * arch_regs[rm_hi];
            end
            K_MOV: begin
                r.reg_we = 1'b1; r.rf_index = rn; r.reg_value = arch_regs[rm_hi];
            end
            default: begin
                // indirect load, address from low byte of the register
                r.reg_we = 1'b1; r.rf_index = rn;
                r.reg_value = arch_mem[arch_regs[rm_lo][ADDR_BITS-1:0]];
            end
        endcase
        if (r.reg_we)
            arch_regs[rn] = r.reg_value;
        if (r.mem_we)
            arch_mem[r.dm_addr] = r.mem_value;
        arch_pc   = pc_next;
        r.next_pc = pc_next;
        return r;
    endfunction

    task automatic report_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            $display("tb: mismatch %s got %0h expected %0h at cycle %0d",
                     name, got, want, cycle_count);
            error_count++;
        end
    endtask

    // beat monitor: predict on input beats, check output beats
    always @(posedge aclk) begin
        result_t      got;
        exec_result_t want;
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken)
            expected_results.push_back(execute_instr(s_tuser, s_tdata[3:0], s_tdata[11:4]));
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(result_t)-1:0];
            if (expected_results.size() == 0) begin
                $display("tb: unexpected result beat at cycle %0d", cycle_count);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                report_field("next_pc",   got.next_pc,   want.next_pc);
                report_field("cycles",    got.cycles,    want.cycles);
                report_field("illegal",   m_tuser,       want.illegal);
                report_field("reg_we",    got.reg_we,    want.reg_we);
                report_field("rf_index",  got.rf_index,  want.rf_index);
                report_field("reg_value", got.reg_value, want.reg_value);
                report_field("mem_we",    got.mem_we,    want.mem_we);
                report_field("dm_addr",   got.dm_addr,   want.dm_addr);
                report_field("mem_value", got.mem_value, want.mem_value);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // result side stalls in short bursts
    always @(negedge aclk) begin
        if (rx_stall_left != 0) begin
            m_tready <= 1'b0;
            rx_stall_left--;
        end else if (aresetn && idle_en && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_stall_left = $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // send one instruction beat, called at a falling edge
    task automatic send_instr(logic [KIND_BITS-1:0] kind, reg_idx_t rn, logic [7:0] opnd);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, opnd, rn};
        do @(negedge aclk); while (!in_taken);
    endtask

    // extremes, every kind and the special cases
    task automatic test_directed();
        send_instr(K_LD_IMM, 4'd15, 8'hff);
        send_instr(K_LD_IMM, 4'd1,  8'h80);
        send_instr(K_MUL,    4'd15, 8'hf0);     // square r15
        send_instr(K_MUL,    4'd15, 8'hf0);
        send_instr(K_MUL,    4'd15, 8'hf0);     // wraps to low 32 bits
        send_instr(K_SUB,    4'd0,  8'hf0);     // negative result
        send_instr(K_ADD,    4'd1,  8'h00);
        send_instr(K_ADD,    4'd0,  8'h0f);
        send_instr(K_MOV,    4'd2,  8'hf0);
        send_instr(K_ST_DIR, 4'd15, 8'hff);
        send_instr(K_ST_DIR, 4'd0,  8'h00);
        send_instr(K_ST_IND, 4'd15, 8'h01);     // address from low byte only
        send_instr(K_LD_DIR, 4'd3,  8'hff);
        send_instr(K_LD_DIR, 4'd4,  8'h00);
        send_instr(K_LD_IND, 4'd5,  8'h0f);
        send_instr(K_LD_IND, 4'd6,  8'hf2);
        send_instr(K_JZ,     4'd7,  8'hff);     // taken, largest offset
        send_instr(K_JZ,     4'd15, 8'h10);     // not taken
        send_instr(K_JZ,     4'd8,  8'h00);     // taken, zero offset
        send_instr(KIND_BAD_FIRST, 4'd15, 8'hff);
        send_instr(KIND_BAD_LAST,  4'd0,  8'h00);
        send_instr(K_SUB,    4'd9,  8'h90);     // self subtract gives zero
        send_instr(K_LD_IMM, 4'd0,  8'h00);
    endtask

    // enough taken jumps to wrap the pc
    task automatic test_pc_wrap();
        send_instr(K_LD_IMM, 4'd10, 8'h00);
        repeat (260)
            send_instr(K_JZ, 4'd10, 8'hff);
    endtask

    // random instruction streams, biased towards reuse of state
    task automatic test_random_program(int count, bit with_idle);
        logic [KIND_BITS-1:0] kind;
        reg_idx_t             rn;
        logic [7:0]           opnd;
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0)
                idle_en = with_idle && ($urandom_range(0, 3) != 0);
            rn   = REG_IDX_BITS'($urandom_range(0, 15));
            opnd = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 8)
                kind = KIND_BITS'($urandom_range(KIND_BAD_FIRST, KIND_BAD_LAST));
            else
                kind = KIND_BITS'($urandom_range(K_LD_DIR, K_LD_IND));
            case (kind)
                K_LD_DIR, K_ST_DIR: if ($urandom_range(0, 1) == 0)
                                        opnd = 8'($urandom_range(0, 15));
                K_LD_IMM:           if ($urandom_range(0, 3) == 0) opnd = 8'h00;
                K_SUB:              if ($urandom_range(0, 2) == 0) opnd[7:4] = rn;
                default: ;
            endcase
            send_instr(kind, rn, opnd);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (arch_regs[i]) arch_regs[i] = '0;
        foreach (arch_mem[i])  arch_mem[i]  = '0;
        arch_pc = '0;
        @(negedge aclk);

        test_directed();
        test_pc_wrap();
        test_random_program(1300, 1'b1);
        test_random_program(250, 1'b0);
        s_tvalid <= 1'b0;

        // drain
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
sv/tce_pkg.sv
sv/tce_rf.sv
sv/tce_ofifo.sv
sv/tiny_cpu_execute_unit.sv
tb/sv/tb.sv
